// ----- hw/rtl/http_request_line_parser_assert.svh -----
// ----------------------------------------------------------------------------
// Request line parser assertion macros
// Forms for the concurrent checks of the parser core module.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HRLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HRLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hrlp_pkg.sv -----
// ----------------------------------------------------------------------------
// Request line parser package
// Types, codes and character tables shared by the parser modules.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  typedef enum logic [3:0] {
    PH_METHOD,
    PH_URI,
    PH_PROTO,
    PH_MAJOR,
    PH_MINOR,
    PH_LF,
    PH_IDLE
  } phase_t;

  localparam logic [1:0] KIND_URI  = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_IMPL = 2'd1;
  localparam logic [1:0] ST_URI_LONG = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam logic [2:0] PROTO_LAST = 3'd4;

  localparam logic [15:0] MAX_URI_RESET = 16'd1024;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
    logic       new_request;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  uri_char;
    logic [2:0]  method_code;
    logic [15:0] uri_length;
    logic [15:0] version_major;
    logic [15:0] version_minor;
    logic [1:0]  status;
  } result_t;

  function automatic logic [2:0] verb_len(input logic [2:0] idx);
    logic [2:0] len;
    case (idx)
      3'd0:    len = 3'd7;
      3'd1:    len = 3'd3;
      3'd2:    len = 3'd4;
      3'd3:    len = 3'd4;
      3'd4:    len = 3'd3;
      3'd5:    len = 3'd6;
      3'd6:    len = 3'd5;
      3'd7:    len = 3'd7;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [63:0] verb_text(input logic [2:0] idx);
    logic [63:0] w;
    case (idx)
      3'd0:    w = {"OPTIONS", 8'h00};
      3'd1:    w = {"GET", 40'h0};
      3'd2:    w = {"HEAD", 32'h0};
      3'd3:    w = {"POST", 32'h0};
      3'd4:    w = {"PUT", 40'h0};
      3'd5:    w = {"DELETE", 16'h0};
      3'd6:    w = {"TRACE", 24'h0};
      3'd7:    w = {"CONNECT", 8'h00};
      default: w = 64'h0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] verb_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [63:0] w;
    int          sh;
    w  = verb_text(idx);
    sh = (7 - int'(pos)) * 8;
    return w[sh +: 8];
  endfunction

  function automatic logic [7:0] proto_char(input logic [2:0] pos);
    logic [63:0] w;
    int          sh;
    w  = {"HTTP/", 24'h0};
    sh = (7 - int'(pos)) * 8;
    return w[sh +: 8];
  endfunction

  function automatic result_t err_result(input logic [1:0] st);
    result_t r;
    r        = '0;
    r.kind   = KIND_ERR;
    r.status = st;
    return r;
  endfunction

endpackage

// ----- hw/rtl/http_request_line_parser.sv -----
// ----------------------------------------------------------------------------
// HTTP request line parser
// Parses method, URI and version of one request line from a byte stream.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle and streams URI bytes out as
// they arrive, followed by one summary or error result per request line.
// Each transfer passes an input register, the parsing logic and a result
// register, and a new byte is taken every cycle while the result side keeps
// up; the combinational parse step and the one-deep result register set this
// rate.
module http_request_line_parser #(
  parameter int METHOD_MAX_LEN = 16,
  parameter int VERSION_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_of_stream,
  input  logic        in_new_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_uri_char,
  output logic [2:0]  out_method_code,
  output logic [15:0] out_uri_length,
  output logic [15:0] out_version_major,
  output logic [15:0] out_version_minor,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import hrlp_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_vld;
  logic    step_go;
  logic    res_vld;
  result_t res;
  result_t out_res;

  assign in_item.byte_value    = in_byte_value;
  assign in_item.end_of_stream = in_end_of_stream;
  assign in_item.new_request   = in_new_request;

  assign step_go = item_vld && (!out_valid || out_ready);

  hrlp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (step_go),
    .item_vld (item_vld),
    .item     (item)
  );

  hrlp_core #(
    .METHOD_MAX_LEN (METHOD_MAX_LEN),
    .VERSION_BITS   (VERSION_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_go     (step_go),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_vld     (res_vld),
    .res         (res)
  );

  hrlp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_go && res_vld),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_uri_char      = out_res.uri_char;
  assign out_method_code   = out_res.method_code;
  assign out_uri_length    = out_res.uri_length;
  assign out_version_major = out_res.version_major;
  assign out_version_minor = out_res.version_minor;
  assign out_status        = out_res.status;

endmodule

// ----- hw/rtl/hrlp_in_reg.sv -----
// ----------------------------------------------------------------------------
// Request line parser input register
// Holds one accepted item until the parsing step consumes it.
// ----------------------------------------------------------------------------
module hrlp_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hrlp_pkg::item_t in_item,
  input  logic           take,
  output logic           item_vld,
  output hrlp_pkg::item_t item
);
  import hrlp_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  assign in_ready = !vld_r || take;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_comb begin
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hw/rtl/hrlp_core.sv -----
// ----------------------------------------------------------------------------
// Request line parser step logic
// Parse state, the URI length limit and the per-byte decision logic.
// ----------------------------------------------------------------------------
`include "http_request_line_parser_assert.svh"

module hrlp_core #(
  parameter int METHOD_MAX_LEN = 16,
  parameter int VERSION_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_go,
  input  hrlp_pkg::item_t  item,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  output logic             res_vld,
  output hrlp_pkg::result_t res
);
  import hrlp_pkg::*;

  localparam int MCW = $clog2(METHOD_MAX_LEN + 1);
  localparam int VB  = VERSION_BITS;
  localparam logic [MCW-1:0] MC_MAX = MCW'(METHOD_MAX_LEN);

  phase_t          phase_r,  phase_nxt,  e_phase;
  logic [7:0]      cand_r,   cand_nxt,   e_cand;
  logic [MCW-1:0]  mcount_r, mcount_nxt, e_mcount;
  logic [15:0]     uri_r,    uri_nxt,    e_uri;
  logic [2:0]      lit_r,    lit_nxt,    e_lit;
  logic [VB-1:0]   major_r,  major_nxt,  e_major;
  logic [VB-1:0]   minor_r,  minor_nxt,  e_minor;
  logic            digit_r,  digit_nxt,  e_digit;
  logic [2:0]      chosen_r, chosen_nxt, e_chosen;
  logic [15:0]     max_uri_r;

  logic [7:0]      b;
  logic            eos;
  logic            is_sp;
  logic            is_digit;
  logic [7:0]      dsub;
  logic [3:0]      dval;
  logic [7:0]      cand_keep;
  logic [7:0]      hit;
  logic            any_hit;
  logic [2:0]      chosen_sel;
  logic [VB+3:0]   maj_sum;
  logic [VB+3:0]   min_sum;
  logic            maj_ovf;
  logic            min_ovf;
  logic            proto_ok;
  logic            uri_long;
  logic [VB+15:0]  major_wide;
  logic [VB+15:0]  minor_wide;
  logic            idle_step;
  logic            uri_out;
  logic            end_out;

  always_comb begin
    if (item.new_request) begin
      e_phase  = PH_METHOD;
      e_cand   = 8'hFF;
      e_mcount = '0;
      e_uri    = '0;
      e_lit    = '0;
      e_major  = '0;
      e_minor  = '0;
      e_digit  = 1'b0;
      e_chosen = '0;
    end else begin
      e_phase  = phase_r;
      e_cand   = cand_r;
      e_mcount = mcount_r;
      e_uri    = uri_r;
      e_lit    = lit_r;
      e_major  = major_r;
      e_minor  = minor_r;
      e_digit  = digit_r;
      e_chosen = chosen_r;
    end
  end

  always_comb begin
    b          = item.byte_value;
    eos        = item.end_of_stream;
    is_sp      = (b == CH_SP);
    is_digit   = (b >= CH_0) && (b <= CH_9);
    dsub       = b - CH_0;
    dval       = dsub[3:0];
    cand_keep  = '0;
    hit        = '0;
    any_hit    = 1'b0;
    chosen_sel = '0;
    for (int i = 0; i < 8; i++) begin
      cand_keep[i] = e_cand[i] && (e_mcount < MCW'(verb_len(3'(i))))
                     && (verb_char(3'(i), e_mcount[2:0]) == b);
      hit[i]       = e_cand[i] && (e_mcount == MCW'(verb_len(3'(i))));
    end
    for (int i = 7; i >= 0; i--) begin
      if (hit[i]) begin
        chosen_sel = 3'(i);
        any_hit    = 1'b1;
      end
    end
    maj_sum    = ((VB+4)'(e_major) << 3) + ((VB+4)'(e_major) << 1) + (VB+4)'(dval);
    min_sum    = ((VB+4)'(e_minor) << 3) + ((VB+4)'(e_minor) << 1) + (VB+4)'(dval);
    maj_ovf    = |maj_sum[VB+3:VB];
    min_ovf    = |min_sum[VB+3:VB];
    proto_ok   = (proto_char(e_lit) == b);
    uri_long   = (e_uri >= max_uri_r);
    major_wide = (VB+16)'(e_major);
    minor_wide = (VB+16)'(e_minor);
  end

  always_comb begin
    phase_nxt  = e_phase;
    cand_nxt   = e_cand;
    mcount_nxt = e_mcount;
    uri_nxt    = e_uri;
    lit_nxt    = e_lit;
    major_nxt  = e_major;
    minor_nxt  = e_minor;
    digit_nxt  = e_digit;
    chosen_nxt = e_chosen;
    case (e_phase)
      PH_METHOD: begin
        if (eos || is_sp) begin
          if (any_hit && !eos) begin
            phase_nxt  = PH_URI;
            chosen_nxt = chosen_sel;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end else begin
          cand_nxt = cand_keep;
          if (e_mcount >= MC_MAX) begin
            phase_nxt = PH_IDLE;
          end else begin
            mcount_nxt = e_mcount + MCW'(1);
          end
        end
      end
      PH_URI: begin
        if (eos) begin
          phase_nxt = PH_IDLE;
        end else if (is_sp) begin
          phase_nxt = PH_PROTO;
          lit_nxt   = '0;
        end else if (uri_long) begin
          phase_nxt = PH_IDLE;
        end else begin
          uri_nxt = e_uri + 16'd1;
        end
      end
      PH_PROTO: begin
        if (eos || !proto_ok) begin
          phase_nxt = PH_IDLE;
        end else if (e_lit == PROTO_LAST) begin
          phase_nxt = PH_MAJOR;
          digit_nxt = 1'b0;
          major_nxt = '0;
        end else begin
          lit_nxt = e_lit + 3'd1;
        end
      end
      PH_MAJOR: begin
        if (eos) begin
          phase_nxt = PH_IDLE;
        end else if (is_digit) begin
          if (maj_ovf) begin
            phase_nxt = PH_IDLE;
          end else begin
            major_nxt = maj_sum[VB-1:0];
            digit_nxt = 1'b1;
          end
        end else if (!e_digit || (b != CH_DOT)) begin
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_MINOR;
          digit_nxt = 1'b0;
          minor_nxt = '0;
        end
      end
      PH_MINOR: begin
        if (eos) begin
          phase_nxt = PH_IDLE;
        end else if (is_digit) begin
          if (min_ovf) begin
            phase_nxt = PH_IDLE;
          end else begin
            minor_nxt = min_sum[VB-1:0];
            digit_nxt = 1'b1;
          end
        end else if (!e_digit || (b != CH_CR)) begin
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_LF;
        end
      end
      PH_LF: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = e_phase;
      end
    endcase
  end

  always_comb begin
    res_vld = 1'b0;
    res     = '0;
    case (e_phase)
      PH_METHOD: begin
        if (eos || is_sp) begin
          if (!(any_hit && !eos)) begin
            res_vld = 1'b1;
            res     = err_result(any_hit ? ST_BAD : ST_NOT_IMPL);
          end
        end else if (e_mcount >= MC_MAX) begin
          res_vld = 1'b1;
          res     = err_result(ST_NOT_IMPL);
        end
      end
      PH_URI: begin
        if (eos) begin
          res_vld = 1'b1;
          res     = err_result(ST_BAD);
        end else if (!is_sp) begin
          res_vld = 1'b1;
          if (uri_long) begin
            res = err_result(ST_URI_LONG);
          end else begin
            res.kind     = KIND_URI;
            res.uri_char = b;
          end
        end
      end
      PH_PROTO: begin
        if (eos || !proto_ok) begin
          res_vld = 1'b1;
          res     = err_result(ST_BAD);
        end
      end
      PH_MAJOR: begin
        if (eos || (is_digit && maj_ovf) || (!is_digit && (!e_digit || (b != CH_DOT)))) begin
          res_vld = 1'b1;
          res     = err_result(ST_BAD);
        end
      end
      PH_MINOR: begin
        if (eos || (is_digit && min_ovf) || (!is_digit && (!e_digit || (b != CH_CR)))) begin
          res_vld = 1'b1;
          res     = err_result(ST_BAD);
        end
      end
      PH_LF: begin
        res_vld = 1'b1;
        if (eos || (b != CH_LF)) begin
          res = err_result(ST_BAD);
        end else begin
          res.kind          = KIND_LINE;
          res.method_code   = e_chosen;
          res.uri_length    = e_uri;
          res.version_major = major_wide[15:0];
          res.version_minor = minor_wide[15:0];
          res.status        = ST_OK;
        end
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_METHOD;
      cand_r    <= 8'hFF;
      mcount_r  <= '0;
      uri_r     <= '0;
      lit_r     <= '0;
      major_r   <= '0;
      minor_r   <= '0;
      digit_r   <= 1'b0;
      chosen_r  <= '0;
      max_uri_r <= MAX_URI_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_uri_r <= cfg_wr_data;
      end
      if (step_go) begin
        phase_r  <= phase_nxt;
        cand_r   <= cand_nxt;
        mcount_r <= mcount_nxt;
        uri_r    <= uri_nxt;
        lit_r    <= lit_nxt;
        major_r  <= major_nxt;
        minor_r  <= minor_nxt;
        digit_r  <= digit_nxt;
        chosen_r <= chosen_nxt;
      end
    end
  end

  assign idle_step = step_go && !item.new_request && (phase_r == PH_IDLE);
  assign uri_out   = step_go && res_vld && (res.kind == KIND_URI);
  assign end_out   = step_go && res_vld && (res.kind != KIND_URI);

  `HRLP_ASSERT_NOW(a_idle_silent, idle_step, !res_vld, "parser produced a result while finished")
  `HRLP_ASSERT_NEXT(a_uri_stays, uri_out, phase_r == PH_URI && uri_r != '0, "URI byte out of phase")
  `HRLP_ASSERT_NEXT(a_end_idle, end_out, phase_r == PH_IDLE, "final result did not end the request")
  `HRLP_ASSERT_NOW(a_mcount_bound, phase_r == PH_METHOD, mcount_r <= MC_MAX, "method too long")

endmodule

// ----- hw/rtl/hrlp_out_reg.sv -----
// ----------------------------------------------------------------------------
// Request line parser result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module hrlp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hrlp_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output hrlp_pkg::result_t out_res
);
  import hrlp_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
